// ----- rtl/rcs_pkg.sv -----
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants of the rounded clip span block.
// ----------------------------------------------------------------------------
`default_nettype none

package rcs_pkg;

  // Field widths
  localparam int COORD_BITS = 16;
  localparam int RAD_BITS   = 12;
  localparam int SPAN_BITS  = 13;
  localparam int SQ_BITS    = 2 * RAD_BITS;
  localparam int SQRT_STEPS = SQ_BITS / 2;
  localparam int WIDE_BITS  = COORD_BITS + 3;
  localparam int ADDR_BITS  = 5;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_REGION_ENABLE = 3'd1;
  localparam logic [2:0] REG_REGION_LEFT   = 3'd2;
  localparam logic [2:0] REG_REGION_TOP    = 3'd3;
  localparam logic [2:0] REG_REGION_RIGHT  = 3'd4;
  localparam logic [2:0] REG_REGION_BOTTOM = 3'd5;

  localparam logic [SPAN_BITS-1:0] SCREEN_WIDTH_RST = SPAN_BITS'(1024);

  // Per-row context carried down the chain
  typedef struct packed {
    logic                         zero;      // row outside the round clip
    logic                         near;      // row inside the rounded corner band
    logic                         round_en;
    logic [RAD_BITS-1:0]          rad;
    logic signed [COORD_BITS-1:0] row_y;
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] x1;
  } ctx_t;

  // Square root working state
  typedef struct packed {
    logic [SQ_BITS-1:0] rem;
    logic [SQ_BITS-1:0] root;
  } sqrt_t;

  // Configuration registers
  typedef struct packed {
    logic [SPAN_BITS-1:0]         screen_width;
    logic                         region_en;
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic signed [COORD_BITS-1:0] right;
    logic signed [COORD_BITS-1:0] bottom;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/rcs_if.sv -----
// ----------------------------------------------------------------------------
// rcs_if
// Valid/ready channels of the rounded clip span block: row word in,
// span word out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] row_y;
  logic        round_enable;
  logic [15:0] round_left;
  logic [15:0] round_top;
  logic [15:0] round_right;
  logic [15:0] round_bottom;
  logic [11:0] corner_radius;

  modport source (output valid, row_y, round_enable, round_left, round_top,
                  round_right, round_bottom, corner_radius, input ready);
  modport sink   (input valid, row_y, round_enable, round_left, round_top,
                  round_right, round_bottom, corner_radius, output ready);
endinterface

interface rcs_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] span_start;
  logic [12:0] span_end;

  modport source (output valid, span_start, span_end, input ready);
  modport sink   (input valid, span_start, span_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/rounded_clip_span_top.sv -----
// ----------------------------------------------------------------------------
// rounded_clip_span_top
// Allowed horizontal span of one raster row under a rounded-bottom clip
// rectangle, a region rectangle and the screen width.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              word
//  in_ch     in   valid/ready            row_y, round clip rectangle, radius
//  out_ch    out  valid/ready            span_start, span_end
//  cfg       in   APB (psel..pready)     screen width, region rectangle
//
//  One word per cycle sustained unless out_ch stalls; the stages are the front cell with
//  the two squares, twelve square-root digit cells, then the span cell.
//  The whole chain advances together and holds while a finished word waits
//  on out_ch; in_ch.ready is low only then.
//  Synchronous active-low reset clears the valid bits and the config registers; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rounded_clip_span_top import rcs_pkg::*; #(
  parameter int MAX_SCREEN_WIDTH = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  rcs_in_if.sink                    in_ch,
  rcs_out_if.source                 out_ch,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  cfg_t               cfg;
  logic               en;
  logic               front_v;
  ctx_t               front_ctx;
  logic [SQ_BITS-1:0] rr, dd;

  logic  [SQRT_STEPS:0] chain_v;
  ctx_t  [SQRT_STEPS:0] chain_ctx;
  sqrt_t [SQRT_STEPS:0] chain_sq;

  // chain moves unless the output word is held
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  rcs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcs_front_cell u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (in_ch.valid),
    .row_y    (in_ch.row_y),
    .round_en (in_ch.round_enable),
    .x0       (in_ch.round_left),
    .y0       (in_ch.round_top),
    .x1       (in_ch.round_right),
    .y1       (in_ch.round_bottom),
    .rad      (in_ch.corner_radius),
    .v_out    (front_v),
    .ctx_out  (front_ctx),
    .rr_out   (rr),
    .dd_out   (dd)
  );

  // radicand r*r - (r-d)^2 enters the root chain
  assign chain_v[0]       = front_v;
  assign chain_ctx[0]     = front_ctx;
  assign chain_sq[0].rem  = rr - dd;
  assign chain_sq[0].root = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    rcs_sqrt_cell #(
      .STEP (SQRT_STEPS - 1 - k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .v_in    (chain_v[k]),
      .ctx_in  (chain_ctx[k]),
      .sq_in   (chain_sq[k]),
      .v_out   (chain_v[k+1]),
      .ctx_out (chain_ctx[k+1]),
      .sq_out  (chain_sq[k+1])
    );
  end

  rcs_span_cell #(
    .MAX_SCREEN_WIDTH (MAX_SCREEN_WIDTH)
  ) u_span (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .v_in       (chain_v[SQRT_STEPS]),
    .ctx_in     (chain_ctx[SQRT_STEPS]),
    .root       (chain_sq[SQRT_STEPS].root[RAD_BITS-1:0]),
    .cfg        (cfg),
    .v_out      (out_ch.valid),
    .span_start (out_ch.span_start),
    .span_end   (out_ch.span_end)
  );

endmodule

`default_nettype wire

// ----- rtl/rcs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// rcs_cfg_regs
// APB register file: screen width and region rectangle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_cfg_regs import rcs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_BITS-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_SCREEN_WIDTH:  cfg_nxt.screen_width = pwdata[SPAN_BITS-1:0];
        REG_REGION_ENABLE: cfg_nxt.region_en    = pwdata[0];
        REG_REGION_LEFT:   cfg_nxt.left         = pwdata[COORD_BITS-1:0];
        REG_REGION_TOP:    cfg_nxt.top          = pwdata[COORD_BITS-1:0];
        REG_REGION_RIGHT:  cfg_nxt.right        = pwdata[COORD_BITS-1:0];
        REG_REGION_BOTTOM: cfg_nxt.bottom       = pwdata[COORD_BITS-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width <= SCREEN_WIDTH_RST;
      cfg_r.region_en    <= 1'b0;
      cfg_r.left         <= '0;
      cfg_r.top          <= '0;
      cfg_r.right        <= '0;
      cfg_r.bottom       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux, raw register bits
  always_comb begin
    unique case (idx)
      REG_SCREEN_WIDTH:  prdata = 32'(cfg_r.screen_width);
      REG_REGION_ENABLE: prdata = 32'(cfg_r.region_en);
      REG_REGION_LEFT:   prdata = 32'(unsigned'(cfg_r.left));
      REG_REGION_TOP:    prdata = 32'(unsigned'(cfg_r.top));
      REG_REGION_RIGHT:  prdata = 32'(unsigned'(cfg_r.right));
      REG_REGION_BOTTOM: prdata = 32'(unsigned'(cfg_r.bottom));
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/rcs_front_cell.sv -----
// ----------------------------------------------------------------------------
// rcs_front_cell
// Head of the chain: round clip row test, corner band test and the two
// squares r*r and (r-d)*(r-d).
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_front_cell import rcs_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         v_in,
  input  wire logic signed [COORD_BITS-1:0] row_y,
  input  wire logic                         round_en,
  input  wire logic signed [COORD_BITS-1:0] x0,
  input  wire logic signed [COORD_BITS-1:0] y0,
  input  wire logic signed [COORD_BITS-1:0] x1,
  input  wire logic signed [COORD_BITS-1:0] y1,
  input  wire logic [RAD_BITS-1:0]          rad,
  output logic                              v_out,
  output ctx_t                              ctx_out,
  output logic [SQ_BITS-1:0]                rr_out,
  output logic [SQ_BITS-1:0]                dd_out
);

  logic                        v_r;
  ctx_t                        ctx_r, ctx_nxt;
  logic [SQ_BITS-1:0]          rr_r, dd_r;
  logic signed [COORD_BITS:0]  row_dist;
  logic [RAD_BITS-1:0]         dy;
  logic                        outside;

  // distance from the bottom edge and the corner band test
  always_comb begin
    outside  = (row_y < y0) || (row_y > y1);
    row_dist = (COORD_BITS+1)'(y1) - (COORD_BITS+1)'(row_y);
    ctx_nxt.zero     = round_en && outside;
    ctx_nxt.near     = round_en && !outside &&
                       (row_dist < signed'({{(COORD_BITS-RAD_BITS+1){1'b0}}, rad}));
    ctx_nxt.round_en = round_en;
    ctx_nxt.rad      = rad;
    ctx_nxt.row_y    = row_y;
    ctx_nxt.x0       = x0;
    ctx_nxt.x1       = x1;
    dy = rad - row_dist[RAD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r <= ctx_nxt;
      rr_r  <= SQ_BITS'(rad) * SQ_BITS'(rad);
      dd_r  <= SQ_BITS'(dy) * SQ_BITS'(dy);
    end
  end

  assign v_out   = v_r;
  assign ctx_out = ctx_r;
  assign rr_out  = rr_r;
  assign dd_out  = dd_r;

endmodule

`default_nettype wire

// ----- rtl/rcs_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// rcs_sqrt_cell
// One digit step of the floor square root; passes the row context along.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_sqrt_cell import rcs_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  v_in,
  input  wire ctx_t  ctx_in,
  input  wire sqrt_t sq_in,
  output logic       v_out,
  output ctx_t       ctx_out,
  output sqrt_t      sq_out
);

  localparam logic [SQ_BITS-1:0] BIT = SQ_BITS'(1) << (2 * STEP);

  logic               v_r;
  ctx_t               ctx_r;
  sqrt_t              sq_r, sq_nxt;
  logic [SQ_BITS:0]   trial;

  // restoring step: try root + bit against the remainder
  always_comb begin
    trial = {1'b0, sq_in.root} + {1'b0, BIT};
    if ({1'b0, sq_in.rem} >= trial) begin
      sq_nxt.rem  = sq_in.rem - trial[SQ_BITS-1:0];
      sq_nxt.root = (sq_in.root >> 1) + BIT;
    end else begin
      sq_nxt.rem  = sq_in.rem;
      sq_nxt.root = sq_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r <= ctx_in;
      sq_r  <= sq_nxt;
    end
  end

  assign v_out   = v_r;
  assign ctx_out = ctx_r;
  assign sq_out  = sq_r;

endmodule

`default_nettype wire

// ----- rtl/rcs_span_cell.sv -----
// ----------------------------------------------------------------------------
// rcs_span_cell
// Tail of the chain: applies the corner inset, the region rectangle and the
// screen clamp, and holds the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_span_cell import rcs_pkg::*; #(
  parameter int MAX_SCREEN_WIDTH = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                v_in,
  input  wire ctx_t                ctx_in,
  input  wire logic [RAD_BITS-1:0] root,
  input  wire cfg_t                cfg,
  output logic                     v_out,
  output logic [SPAN_BITS-1:0]     span_start,
  output logic [SPAN_BITS-1:0]     span_end
);

  localparam logic signed [WIDE_BITS-1:0] MAX_W = WIDE_BITS'(MAX_SCREEN_WIDTH);

  logic                        v_r;
  logic [SPAN_BITS-1:0]        start_r, end_r;
  logic [RAD_BITS-1:0]         ins;
  logic signed [WIDE_BITS-1:0] w, cl, cr, gl, gr, lo, hi;
  logic                        zero;

  always_comb begin
    // screen width, capped
    w = signed'(WIDE_BITS'(cfg.screen_width));
    if (w > MAX_W) w = MAX_W;

    // rounded clip columns
    ins = ctx_in.near ? (ctx_in.rad - root) : '0;
    cl  = WIDE_BITS'(ctx_in.x0) + signed'(WIDE_BITS'(ins));
    cr  = WIDE_BITS'(ctx_in.x1) + WIDE_BITS'(1) - signed'(WIDE_BITS'(ins));
    gl  = WIDE_BITS'(cfg.left);
    gr  = WIDE_BITS'(cfg.right) + WIDE_BITS'(1);

    lo   = '0;
    hi   = w;
    zero = ctx_in.zero;
    if (ctx_in.round_en) begin
      if (cl > lo) lo = cl;
      if (cr < hi) hi = cr;
    end

    // region rectangle
    if (cfg.region_en) begin
      if (ctx_in.row_y < cfg.top || ctx_in.row_y > cfg.bottom) zero = 1'b1;
      if (gl > lo) lo = gl;
      if (gr < hi) hi = gr;
    end

    // screen clamp, disjoint span collapses
    if (lo < 0) lo = '0;
    if (lo > w) lo = w;
    if (hi > w) hi = w;
    if (hi < lo) hi = lo;
    if (zero) begin
      lo = '0;
      hi = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      start_r <= lo[SPAN_BITS-1:0];
      end_r   <= hi[SPAN_BITS-1:0];
    end
  end

  assign v_out      = v_r;
  assign span_start = start_r;
  assign span_end   = end_r;

endmodule

`default_nettype wire

// ----- tb/tb_rounded_clip_span_top.sv -----
// ----------------------------------------------------------------------------
// tb_rounded_clip_span_top
// Self-checking bench for the rounded clip span block. Row words go in
// through a valid/ready channel with random gaps, and span words are taken
// out with random stalls. Each span word is checked against an in-bench
// span calculator that works from a shadow copy of the registers. Registers
// are changed over the APB port only while the pipe is empty, and every
// register is read back after it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rounded_clip_span_top;
  import rcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH   = 4096;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 40;

  // One row word as it crosses the input channel
  typedef struct packed {
    logic signed [COORD_BITS-1:0] row_y;
    logic                         round_en;
    logic signed [COORD_BITS-1:0] round_left;
    logic signed [COORD_BITS-1:0] round_top;
    logic signed [COORD_BITS-1:0] round_right;
    logic signed [COORD_BITS-1:0] round_bottom;
    logic [RAD_BITS-1:0]          radius;
  } row_word_t;

  typedef struct packed {
    logic [SPAN_BITS-1:0] start_col;
    logic [SPAN_BITS-1:0] end_col;
  } span_t;

  logic                 clk;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  rcs_in_if  in_ch ();
  rcs_out_if out_ch ();

  rounded_clip_span_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t        cfg_shadow;
  span_t       pending_spans[$];
  bit          rush;
  int unsigned error_count;
  int unsigned rows_sent;
  int unsigned spans_checked;
  int unsigned settings_used;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Expected span of one row under the current registers
  function automatic span_t predict_span(row_word_t w, cfg_t c);
    longint py, wd, lo, hi, cl, cr, d, rad, dy, sq, root, cand, ins;
    span_t  s;
    s  = '0;
    py = $signed(w.row_y);
    wd = c.screen_width;
    if (wd > MAX_WIDTH) wd = MAX_WIDTH;
    lo = 0;
    hi = wd;

    if (w.round_en) begin
      if (py < $signed(w.round_top) || py > $signed(w.round_bottom)) return s;
      cl  = $signed(w.round_left);
      cr  = $signed(w.round_right);
      cr  = cr + 1;
      d   = $signed(w.round_bottom);
      d   = d - py;
      rad = w.radius;
      // inside the corner band both sides pull in by r - isqrt(r^2 - (r-d)^2)
      if (d < rad) begin
        dy   = rad - d;
        sq   = rad * rad - dy * dy;
        root = 0;
        for (int b = RAD_BITS - 1; b >= 0; b--) begin
          cand = root + (longint'(1) << b);
          if (cand * cand <= sq) root = cand;
        end
        ins = rad - root;
        cl  = cl + ins;
        cr  = cr - ins;
      end
      if (cl > lo) lo = cl;
      if (cr < hi) hi = cr;
    end

    if (c.region_en) begin
      if (py < $signed(c.top) || py > $signed(c.bottom)) return s;
      cl = $signed(c.left);
      cr = $signed(c.right);
      cr = cr + 1;
      if (cl > lo) lo = cl;
      if (cr < hi) hi = cr;
    end

    // clamp to the screen; a disjoint span collapses onto its start
    if (lo < 0) lo = 0;
    if (lo > wd) lo = wd;
    if (hi > wd) hi = wd;
    if (hi < lo) hi = lo;
    s.start_col = lo[SPAN_BITS-1:0];
    s.end_col   = hi[SPAN_BITS-1:0];
    return s;
  endfunction

  function automatic int unsigned idle_draw();
    if (rush || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic int width_hint();
    int w;
    w = cfg_shadow.screen_width;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (w < 64) w = 64;
    return w;
  endfunction

  function automatic row_word_t mk_row(int y, bit en, int l, int t, int r, int b, int rad);
    row_word_t w;
    w.row_y        = 16'(y);
    w.round_en     = en;
    w.round_left   = 16'(l);
    w.round_top    = 16'(t);
    w.round_right  = 16'(r);
    w.round_bottom = 16'(b);
    w.radius       = 12'(rad);
    return w;
  endfunction

  // Mostly well-formed clip rectangles with rows near the rounded bottom,
  // some rows anywhere around the rectangle, the rest raw noise
  function automatic row_word_t random_row(int wh);
    logic [95:0] raw;
    row_word_t   w;
    int          pick, x0, x1, y0, y1, rad, ry;
    pick = $urandom_range(0, 99);
    raw  = {$urandom, $urandom, $urandom};
    w    = raw[$bits(row_word_t)-1:0];
    if (pick < 15) return w;
    x0  = int'($urandom_range(0, wh + 128)) - 64;
    x1  = x0 + int'($urandom_range(0, wh + 64)) - 8;
    y0  = int'($urandom_range(0, 4000)) - 2000;
    y1  = y0 + int'($urandom_range(0, 600));
    rad = (pick < 25) ? int'($urandom_range(0, 4095)) : int'($urandom_range(0, 200));
    if (pick < 70) ry = y1 + 1 - int'($urandom_range(0, rad + 2));
    else           ry = y0 - 2 + int'($urandom_range(0, y1 - y0 + 4));
    return mk_row(ry, pick < 92, x0, y0, x1, y1, rad);
  endfunction

  // One row word onto the input channel, after a random gap
  task automatic send_row(row_word_t w);
    int unsigned gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.row_y         <= w.row_y;
    in_ch.round_enable  <= w.round_en;
    in_ch.round_left    <= w.round_left;
    in_ch.round_top     <= w.round_top;
    in_ch.round_right   <= w.round_right;
    in_ch.round_bottom  <= w.round_bottom;
    in_ch.corner_radius <= w.radius;
    in_ch.valid         <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_spans.push_back(predict_span(w, cfg_shadow));
    rows_sent++;
  endtask

  task automatic send_random_rows(int n);
    repeat (n) send_row(random_row(width_hint()));
  endtask

  // Stop sending and let every expected span word come back
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
  endtask

  // APB transfer: setup cycle, then access cycle until pready
  task automatic cfg_access(logic [2:0] idx, bit wr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int reg_width(logic [2:0] idx);
    case (idx)
      REG_SCREEN_WIDTH:  return SPAN_BITS;
      REG_REGION_ENABLE: return 1;
      default:           return COORD_BITS;
    endcase
  endfunction

  function automatic logic [31:0] shadow_value(logic [2:0] idx);
    case (idx)
      REG_SCREEN_WIDTH:  return 32'(cfg_shadow.screen_width);
      REG_REGION_ENABLE: return 32'(cfg_shadow.region_en);
      REG_REGION_LEFT:   return {16'b0, cfg_shadow.left};
      REG_REGION_TOP:    return {16'b0, cfg_shadow.top};
      REG_REGION_RIGHT:  return {16'b0, cfg_shadow.right};
      default:           return {16'b0, cfg_shadow.bottom};
    endcase
  endfunction

  // Read a register back; only the bits it implements are compared
  task automatic check_reg(logic [2:0] idx);
    logic [31:0] rd, mask;
    cfg_access(idx, 1'b0, '0, rd);
    mask = (32'd1 << reg_width(idx)) - 32'd1;
    if ((rd & mask) !== (shadow_value(idx) & mask)) begin
      $error("register %0d: expected %0h, got %0h", idx, shadow_value(idx) & mask,
             rd & mask);
      error_count++;
    end
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] val);
    logic [31:0] unused;
    cfg_access(idx, 1'b1, val, unused);
    case (idx)
      REG_SCREEN_WIDTH:  cfg_shadow.screen_width = val[SPAN_BITS-1:0];
      REG_REGION_ENABLE: cfg_shadow.region_en    = val[0];
      REG_REGION_LEFT:   cfg_shadow.left         = val[15:0];
      REG_REGION_TOP:    cfg_shadow.top          = val[15:0];
      REG_REGION_RIGHT:  cfg_shadow.right        = val[15:0];
      default:           cfg_shadow.bottom       = val[15:0];
    endcase
    check_reg(idx);
  endtask

  // Full register setting; upper data bits carry junk the block must drop
  task automatic apply_settings(int sw, bit en, int l, int t, int r, int b);
    wait_drained();
    set_reg(REG_SCREEN_WIDTH,  {19'($urandom), 13'(sw)});
    set_reg(REG_REGION_ENABLE, {31'($urandom), en});
    set_reg(REG_REGION_LEFT,   {16'($urandom), 16'(l)});
    set_reg(REG_REGION_TOP,    {16'($urandom), 16'(t)});
    set_reg(REG_REGION_RIGHT,  {16'($urandom), 16'(r)});
    set_reg(REG_REGION_BOTTOM, {16'($urandom), 16'(b)});
    settings_used++;
  endtask

  task automatic random_settings(bit use_region);
    int sw, l, r, t, b;
    sw = $urandom_range(1, MAX_WIDTH);
    l  = int'($urandom_range(0, sw + 200)) - 100;
    r  = l + int'($urandom_range(0, sw)) - 20;
    t  = int'($urandom_range(0, 3700)) - 2200;
    b  = t + int'($urandom_range(0, 2500));
    apply_settings(sw, use_region, l, t, r, b);
  endtask

  // Hand-picked rows: field extremes, rows outside the clip, corner insets,
  // inverted and off-screen rectangles, then a region on top
  task automatic test_directed_edges();
    for (int i = 0; i <= REG_REGION_BOTTOM; i++) check_reg(3'(i));
    send_row(mk_row(-32768, 0, 0, 0, 0, 0, 0));
    send_row(mk_row(32767, 0, -1, -1, -1, -1, 4095));
    send_row(mk_row(10, 1, 100, 20, 199, 40, 0));
    send_row(mk_row(41, 1, 100, 20, 199, 40, 0));
    send_row(mk_row(30, 1, 100, 20, 199, 40, 0));
    send_row(mk_row(40, 1, 100, 20, 199, 40, 8));
    send_row(mk_row(33, 1, 100, 20, 199, 40, 8));
    send_row(mk_row(32, 1, 100, 20, 199, 40, 8));
    send_row(mk_row(40, 1, 100, 0, 199, 40, 4095));
    send_row(mk_row(0, 1, -32768, -32768, 32767, 32767, 0));
    send_row(mk_row(32767, 1, -32768, -32768, 32767, 32767, 4095));
    send_row(mk_row(5, 1, 5000, 0, 6000, 10, 0));
    send_row(mk_row(5, 1, 300, 0, 200, 10, 0));
    send_row(mk_row(5, 1, 10, 10, 20, 0, 0));
    send_row(mk_row(-5, 1, -100, -10, -50, 0, 3));
    apply_settings(1024, 1, 50, 0, 500, 100);
    send_row(mk_row(50, 0, 0, 0, 0, 0, 0));
    send_row(mk_row(101, 0, 0, 0, 0, 0, 0));
    send_row(mk_row(-1, 0, 0, 0, 0, 0, 0));
    send_row(mk_row(60, 1, 0, 0, 1023, 200, 0));
    send_row(mk_row(300, 1, 0, 0, 1023, 200, 0));
    send_row(mk_row(100, 1, 400, 0, 900, 100, 50));
  endtask

  // Zero, one, full and oversized screen widths
  task automatic test_screen_width_limits();
    int widths[4];
    widths = '{0, 1, MAX_WIDTH, 8191};
    for (int i = 0; i < 4; i++) begin
      apply_settings(widths[i], i % 2 == 1, -50, -2000, 2000, 2600);
      send_random_rows(60);
    end
  endtask

  // Region rectangle: plain, full coordinate range, inverted, random
  task automatic test_region_settings();
    apply_settings(1024, 1, 0, -100, 1023, 100);
    send_random_rows(130);
    apply_settings(MAX_WIDTH, 1, -32768, -32768, 32767, 32767);
    send_random_rows(130);
    apply_settings(800, 1, 700, -32768, 300, 32767);
    send_random_rows(130);
    repeat (3) begin
      random_settings(1'b1);
      send_random_rows(130);
    end
  endtask

  // Round clip alone, region off, at random screen widths
  task automatic test_rounded_corners();
    repeat (3) begin
      random_settings(1'b0);
      send_random_rows(100);
    end
  endtask

  // Full rate: no gaps on either side
  task automatic test_back_to_back();
    random_settings(1'b1);
    rush = 1'b1;
    send_random_rows(230);
    wait_drained();
    rush = 1'b0;
  endtask

  // Span word checker with random stalls on ready
  initial begin
    span_t       want;
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_draw();
      @(negedge clk);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_spans.size() == 0) begin
        $error("span word with no row pending: start %0d end %0d",
               out_ch.span_start, out_ch.span_end);
        error_count++;
      end else begin
        want = pending_spans.pop_front();
        if (out_ch.span_start !== want.start_col) begin
          $error("span_start: expected %0d, got %0d", want.start_col, out_ch.span_start);
          error_count++;
        end
        if (out_ch.span_end !== want.end_col) begin
          $error("span_end: expected %0d, got %0d", want.end_col, out_ch.span_end);
          error_count++;
        end
        spans_checked++;
      end
    end
  end

  // Hang guard
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d span words outstanding", cycle_count,
             pending_spans.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_ch.valid          = 1'b0;
    in_ch.row_y          = '0;
    in_ch.round_enable   = 1'b0;
    in_ch.round_left     = '0;
    in_ch.round_top      = '0;
    in_ch.round_right    = '0;
    in_ch.round_bottom   = '0;
    in_ch.corner_radius  = '0;
    cfg_shadow              = '0;
    cfg_shadow.screen_width = SCREEN_WIDTH_RST;
    rush          = 1'b0;
    error_count   = 0;
    rows_sent     = 0;
    spans_checked = 0;
    settings_used = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_screen_width_limits();
    test_region_settings();
    test_rounded_corners();
    test_back_to_back();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d rows and %0d checked span words over %0d register settings,",
             rows_sent, spans_checked, settings_used);
    $display("screen widths 0 to 8191, region on and off, radii up to 4095");
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
